FILE: rtl/core/rpfc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rpfc_pkg
// Shared types, register codes and constants of the RC pulse frame capture.
// ============================================================================
package rpfc_pkg;

    localparam int CHANNELS_DEFAULT  = 9;
    localparam int TIME_BITS_DEFAULT = 16;

    localparam int CHANNEL_W = 4;
    localparam int STAMP_W   = 16;
    localparam int TICK_W    = 16;
    localparam int WIDTH_W   = 15;
    localparam int FOUND_W   = 9;
    localparam int COUNT_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [WIDTH_W-1:0]   WIDTH_MAX     = '1;
    localparam logic [COUNT_W-1:0]   COUNT_MAX     = '1;

    localparam logic [WIDTH_W-1:0]   MIN_WIDTH_RESET       = 15'd1000;
    localparam logic [WIDTH_W-1:0]   MAX_WIDTH_RESET       = 15'd5000;
    localparam logic [CHANNEL_W-1:0] FAILSAFE_CHANNEL_RESET = 4'd3;
    localparam logic [CHANNEL_W-1:0] LAST_CHANNEL_RESET    = 4'd8;
    localparam logic [COUNT_W-1:0]   REQUIRED_PULSES_RESET = 4'd8;
    localparam logic [TICK_W-1:0]    FRAME_TIMEOUT_RESET   = 16'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_WIDTH        = 3'd0,
        REG_MAX_WIDTH        = 3'd1,
        REG_FAILSAFE_CHANNEL = 3'd2,
        REG_LAST_CHANNEL     = 3'd3,
        REG_REQUIRED_PULSES  = 3'd4,
        REG_FRAME_TIMEOUT    = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        OP_EDGE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef struct packed {
        logic [WIDTH_W-1:0]   min_width;
        logic [WIDTH_W-1:0]   max_width;
        logic [CHANNEL_W-1:0] failsafe_channel;
        logic [CHANNEL_W-1:0] last_channel;
        logic [COUNT_W-1:0]   required_pulses;
        logic [TICK_W-1:0]    frame_timeout;
    } cfg_t;

    typedef struct packed {
        op_t                  operation;
        logic [CHANNEL_W-1:0] channel;
        logic                 level;
        logic [STAMP_W-1:0]   timestamp;
        logic [TICK_W-1:0]    current_tick;
    } item_t;

    typedef struct packed {
        logic                 accepted;
        logic [WIDTH_W-1:0]   width;
        logic                 frame_closed;
        logic                 frame_good;
        logic                 failsafe_flag;
        logic [FOUND_W-1:0]   channels_found;
    } result_t;

endpackage

FILE: rtl/core/rpfc_engine.sv
`timescale 1ns / 1ps
// ============================================================================
// rpfc_engine
// Per-channel rise times and frame state; measures pulses and closes frames
// for one item per cycle in which fire is high.
// ============================================================================
module rpfc_engine
    import rpfc_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEFAULT,
    parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    localparam int IDX_W = $clog2(CHANNELS);
    localparam int CMP_W = (TIME_BITS > WIDTH_W) ? TIME_BITS : WIDTH_W;

    logic [TIME_BITS-1:0] rise_reg [CHANNELS];
    logic [CHANNELS-1:0]  found_reg;
    logic [CHANNELS-1:0]  found_next;
    logic                 failsafe_reg;
    logic                 failsafe_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic [TICK_W-1:0]    deadline_reg;
    logic [TICK_W-1:0]    deadline_next;

    logic                 is_tick;
    logic                 ch_ok;
    logic [IDX_W-1:0]     ch_idx;
    logic [TIME_BITS-1:0] stamp;
    logic [TIME_BITS-1:0] diff;
    logic [CMP_W-1:0]     w_full;
    logic [WIDTH_W-1:0]   w_sat;
    logic                 rising;
    logic                 falling;
    logic                 in_window;
    logic                 acc;
    logic [COUNT_W-1:0]   count_inc;
    logic                 last_close;
    logic                 tick_close;
    logic                 close;
    logic [CHANNELS-1:0]  found_after;
    logic                 failsafe_after;

    always_comb
    begin
        is_tick   = (item.operation == OP_TICK);
        ch_ok     = (item.channel != '0) && (32'(item.channel) <= CHANNELS);
        ch_idx    = IDX_W'(item.channel - CHANNEL_W'(1));
        stamp     = TIME_BITS'(item.timestamp);
        diff      = stamp - rise_reg[ch_idx];
        w_full    = CMP_W'(diff >> 1);
        w_sat     = (w_full > CMP_W'(WIDTH_MAX)) ? WIDTH_MAX : w_full[WIDTH_W-1:0];
        rising    = !is_tick && ch_ok && item.level;
        falling   = !is_tick && ch_ok && !item.level;
        in_window = (w_full >= CMP_W'(cfg.min_width)) && (w_full <= CMP_W'(cfg.max_width));
        acc       = falling && in_window;
        count_inc = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + COUNT_W'(1);

        found_after    = found_reg | (acc ? (CHANNELS'(1) << ch_idx) : '0);
        failsafe_after = failsafe_reg | (acc && (item.channel == cfg.failsafe_channel));

        last_close = acc && (item.channel == cfg.last_channel);
        tick_close = is_tick && (item.current_tick >= deadline_reg);
        close      = last_close || tick_close;

        result.accepted       = acc;
        result.width          = falling ? w_sat : '0;
        result.frame_closed   = close;
        result.frame_good     = last_close && (count_inc >= cfg.required_pulses);
        result.failsafe_flag  = close && failsafe_after;
        result.channels_found = FOUND_W'(found_after);

        found_next    = found_reg;
        failsafe_next = failsafe_reg;
        count_next    = count_reg;
        deadline_next = deadline_reg;
        if (fire)
        begin
            if (close)
            begin
                found_next    = '0;
                failsafe_next = 1'b0;
                count_next    = '0;
                deadline_next = item.current_tick + cfg.frame_timeout;
            end
            else
            begin
                found_next    = found_after;
                failsafe_next = failsafe_after;
                count_next    = acc ? count_inc : count_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg    <= '0;
            failsafe_reg <= 1'b0;
            count_reg    <= '0;
            deadline_reg <= FRAME_TIMEOUT_RESET;
            for (int i = 0; i < CHANNELS; i++)
            begin
                rise_reg[i] <= '0;
            end
        end
        else
        begin
            found_reg    <= found_next;
            failsafe_reg <= failsafe_next;
            count_reg    <= count_next;
            deadline_reg <= deadline_next;
            if (fire && rising)
            begin
                rise_reg[ch_idx] <= stamp;
            end
        end
    end

endmodule

FILE: rtl/core/rc_pulse_frame_capture.sv
`timescale 1ns / 1ps
// ============================================================================
// rc_pulse_frame_capture
// Measures RC servo pulse widths per channel and groups them into frames.
//
// Input channel (in_valid / in_ready): one item is a capture edge
// (operation 0: channel, level, timestamp) or a heartbeat tick (operation 1:
// current_tick). Every item gives exactly one result item on the output
// channel (out_valid / out_ready).
// Path: the item is held in the input register, then its result in the result
// register; out_valid rises when the result register is loaded.
// Throughput: one item per cycle while out_ready is high; the frame state
// update is a single compare-and-update between those two registers.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// at the clock edge; write only while no item is in flight.
// Reset: registers return to their defaults, rise times and frame state
// clear, and the deadline is armed at the default frame timeout.
// Stall: while out_ready is low the result holds; one more item is taken
// into the input register, then in_ready drops until the result moves.
// ============================================================================
module rc_pulse_frame_capture
    import rpfc_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEFAULT,
    parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  operation,
    input  logic [CHANNEL_W-1:0]  channel,
    input  logic                  level,
    input  logic [STAMP_W-1:0]    timestamp,
    input  logic [TICK_W-1:0]     current_tick,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  accepted,
    output logic [WIDTH_W-1:0]    width,
    output logic                  frame_closed,
    output logic                  frame_good,
    output logic                  failsafe_flag,
    output logic [FOUND_W-1:0]    channels_found
);

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result;
    result_t result_reg;
    logic    result_valid_reg;
    logic    advance;
    logic    take;

    assign advance  = item_valid_reg && (!result_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_width        <= MIN_WIDTH_RESET;
            cfg_reg.max_width        <= MAX_WIDTH_RESET;
            cfg_reg.failsafe_channel <= FAILSAFE_CHANNEL_RESET;
            cfg_reg.last_channel     <= LAST_CHANNEL_RESET;
            cfg_reg.required_pulses  <= REQUIRED_PULSES_RESET;
            cfg_reg.frame_timeout    <= FRAME_TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MIN_WIDTH:        cfg_reg.min_width        <= cfg_data[WIDTH_W-1:0];
                REG_MAX_WIDTH:        cfg_reg.max_width        <= cfg_data[WIDTH_W-1:0];
                REG_FAILSAFE_CHANNEL: cfg_reg.failsafe_channel <= cfg_data[CHANNEL_W-1:0];
                REG_LAST_CHANNEL:     cfg_reg.last_channel     <= cfg_data[CHANNEL_W-1:0];
                REG_REQUIRED_PULSES:  cfg_reg.required_pulses  <= cfg_data[COUNT_W-1:0];
                REG_FRAME_TIMEOUT:    cfg_reg.frame_timeout    <= cfg_data[TICK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // hold the item until the result register is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.operation    <= op_t'(operation);
            item_reg.channel      <= channel;
            item_reg.level        <= level;
            item_reg.timestamp    <= timestamp;
            item_reg.current_tick <= current_tick;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    rpfc_engine #(
        .CHANNELS  (CHANNELS),
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign out_valid      = result_valid_reg;
    assign accepted       = result_reg.accepted;
    assign width          = result_reg.width;
    assign frame_closed   = result_reg.frame_closed;
    assign frame_good     = result_reg.frame_good;
    assign failsafe_flag  = result_reg.failsafe_flag;
    assign channels_found = result_reg.channels_found;

endmodule
